### src/ait_pkg.sv
// ait_pkg: shared types and constants for the accumulating interval timer
// depends on nothing; used by the interfaces, the divider and the top level
package ait_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CntW    = $clog2(DataW);

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] RegPeriod    = 2'd0;
    localparam logic [CfgIdxW-1:0] RegRepeating = 2'd1;

    // register reset values
    localparam logic [DataW-1:0] PeriodReset    = 32'd1000;
    localparam logic             RepeatingReset = 1'b1;

    // sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

    // divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

### src/ait_item_if.sv
// ait_item_if: input channel carrying one delta beat and its rearm flag
// depends on ait_pkg for the data width
interface ait_item_if;
    logic                     valid;
    logic                     ready;
    logic [ait_pkg::DataW-1:0] delta;
    logic                     rearm;

    modport source (output valid, output delta, output rearm, input ready);
    modport sink   (input valid, input delta, input rearm, output ready);
endinterface

### src/ait_result_if.sv
// ait_result_if: output channel carrying the fire count and enable state
// depends on ait_pkg for the data width
interface ait_result_if;
    logic                     valid;
    logic                     ready;
    logic [ait_pkg::DataW-1:0] fires;
    logic                     enabled_now;

    modport source (output valid, output fires, output enabled_now, input ready);
    modport sink   (input valid, input fires, input enabled_now, output ready);
endinterface

### src/ait_div.sv
// ait_div: restoring divider, one quotient bit per cycle
// depends on ait_pkg for widths and the control/status structs
module ait_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ait_pkg::t_div_ctl         i_ctl,
    input  logic [ait_pkg::DataW-1:0] i_dividend,
    input  logic [ait_pkg::DataW-1:0] i_divisor,
    output ait_pkg::t_div_sts         o_sts,
    output logic [ait_pkg::DataW-1:0] o_quotient,
    output logic [ait_pkg::DataW-1:0] o_remainder
);

    logic [ait_pkg::DataW-1:0] r_rem;
    logic [ait_pkg::DataW-1:0] r_quo;
    logic [ait_pkg::DataW-1:0] r_dvs;
    logic [ait_pkg::CntW-1:0]  r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [ait_pkg::DataW:0]   n_shift;
    logic [ait_pkg::DataW:0]   n_diff;

    // shift in next dividend bit and trial subtract
    always_comb begin
        n_shift = {r_rem, r_quo[ait_pkg::DataW-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
    end

    // sequencing flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ait_pkg::CntW'(ait_pkg::DataW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, one restoring step per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!n_diff[ait_pkg::DataW]) begin
                r_rem <= n_diff[ait_pkg::DataW-1:0];
            end else begin
                r_rem <= n_shift[ait_pkg::DataW-1:0];
            end
            r_quo <= {r_quo[ait_pkg::DataW-2:0], ~n_diff[ait_pkg::DataW]};
        end
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### src/accumulating_interval_timer.sv
// accumulating_interval_timer: adds each delta beat to a wrapping accumulator, reports fires
// path: an accepted beat goes to ST_HOLD, or first to ST_DIV for the 32-step divider on a repeating fire;
// ST_HOLD loads the output register once it is free, and a new beat is taken only back in ST_IDLE,
// so a result may wait for the one before it to be taken
// reset: accumulator 0, enabled 1, period 1000, repeating 1, no result pending
// depends on ait_pkg, ait_item_if, ait_result_if and ait_div
module accumulating_interval_timer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ait_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [ait_pkg::DataW-1:0]      i_cfg_data,
    ait_item_if.sink                       i_item,
    ait_result_if.source                   o_result
);

    ait_pkg::t_state           r_state;
    ait_pkg::t_state           n_state;

    logic [ait_pkg::DataW-1:0] r_period;
    logic                      r_repeating;
    logic [ait_pkg::DataW-1:0] r_acc;
    logic                      r_enabled;
    logic [ait_pkg::DataW-1:0] r_res_fires;
    logic                      r_out_valid;
    logic [ait_pkg::DataW-1:0] r_out_fires;
    logic                      r_out_en;

    logic                      n_accept;
    logic                      n_load;
    logic [ait_pkg::DataW-1:0] n_sum;
    logic                      n_en;
    logic                      n_fire;

    ait_pkg::t_div_ctl         div_ctl;
    ait_pkg::t_div_sts         div_sts;
    logic [ait_pkg::DataW-1:0] div_quo;
    logic [ait_pkg::DataW-1:0] div_rem;

    // beat arithmetic on acceptance
    always_comb begin
        n_accept = i_item.valid && i_item.ready;
        n_sum    = (i_item.rearm ? '0 : r_acc) + i_item.delta;
        n_en     = r_enabled || i_item.rearm;
        n_fire   = n_en && (i_item.delta != '0) && (r_period != '0) && (n_sum >= r_period);
    end

    assign i_item.ready  = (r_state == ait_pkg::ST_IDLE);
    assign div_ctl.start = n_accept && n_fire && r_repeating;

    ait_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (n_sum),
        .i_divisor   (r_period),
        .o_sts       (div_sts),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ait_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and output load
    always_comb begin
        n_state = r_state;
        n_load  = 1'b0;
        case (r_state)
            ait_pkg::ST_IDLE: begin
                if (n_accept) begin
                    n_state = div_ctl.start ? ait_pkg::ST_DIV : ait_pkg::ST_HOLD;
                end
            end
            ait_pkg::ST_DIV: begin
                if (div_sts.done) begin
                    n_state = ait_pkg::ST_HOLD;
                end
            end
            ait_pkg::ST_HOLD: begin
                if (!r_out_valid || o_result.ready) begin
                    n_load  = 1'b1;
                    n_state = ait_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ait_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= ait_pkg::PeriodReset;
            r_repeating <= ait_pkg::RepeatingReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ait_pkg::RegPeriod:    r_period    <= i_cfg_data;
                ait_pkg::RegRepeating: r_repeating <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // timer state and pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_enabled <= 1'b1;
        end else if (n_accept) begin
            r_acc     <= n_sum;
            r_enabled <= n_en && !(n_fire && !r_repeating);
        end else if (r_state == ait_pkg::ST_DIV && div_sts.done) begin
            r_acc <= div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_res_fires <= n_fire ? ait_pkg::DataW'(1) : '0;
        end else if (r_state == ait_pkg::ST_DIV && div_sts.done) begin
            r_res_fires <= div_quo;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_fires <= r_res_fires;
            r_out_en    <= r_enabled;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.fires       = r_out_fires;
    assign o_result.enabled_now = r_out_en;

endmodule

### src/ait_checker.sv
// ait_checker: port-level checks on the accumulating interval timer
// depends on ait_pkg; bound to accumulating_interval_timer below
module ait_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [ait_pkg::DataW-1:0] i_out_fires,
    input logic                      i_out_enabled_now
);

    // one beat in flight: input closes right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted beat");

    // no result straight out of reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_fires) && $stable(i_out_enabled_now)))
        else $error("stalled result dropped or changed");

endmodule

bind accumulating_interval_timer ait_checker u_ait_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_item.valid),
    .i_in_ready        (i_item.ready),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_out_fires       (o_result.fires),
    .i_out_enabled_now (o_result.enabled_now)
);

### bench/tb_accumulating_interval_timer.sv
// tb_accumulating_interval_timer: directed table then random delta beats through the interval timer
// every result beat is checked against a typed-in result or a local fire-count model held in this module
// depends on ait_pkg, ait_item_if, ait_result_if and accumulating_interval_timer
module tb_accumulating_interval_timer;
    timeunit 1ns;
    timeprecision 1ps;

    // local names for the package constants used below
    localparam int unsigned        DataW          = ait_pkg::DataW;
    localparam int unsigned        CfgIdxW        = ait_pkg::CfgIdxW;
    localparam logic [CfgIdxW-1:0] RegPeriod      = ait_pkg::RegPeriod;
    localparam logic [CfgIdxW-1:0] RegRepeating   = ait_pkg::RegRepeating;
    localparam logic [DataW-1:0]   PeriodReset    = ait_pkg::PeriodReset;
    localparam logic               RepeatingReset = ait_pkg::RepeatingReset;

    localparam int unsigned CycleLimit    = 400000;
    localparam int unsigned DrainCycles   = 40;
    localparam int unsigned NumPhases     = 9;
    localparam int unsigned BeatsPerPhase = 122;
    localparam int unsigned ReportCap     = 50;

    // indexes past the register list, writes there must be ignored
    localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
    localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;

    typedef enum logic {
        ROW_CFG,
        ROW_BEAT
    } t_row_kind;

    // one directed step: a register write, or a beat with an optional typed-in result
    typedef struct packed {
        t_row_kind          kind;
        logic [CfgIdxW-1:0] idx;
        logic [DataW-1:0]   value;
        logic               rearm;
        logic               typed;
        logic [DataW-1:0]   fires;
        logic               enabled;
    } t_row;

    typedef struct packed {
        logic [DataW-1:0] fires;
        logic             enabled;
    } t_tick;

    localparam int unsigned NumRows = 30;
    localparam t_row DirectedRows [NumRows] = '{
        // reset settings: period 1000, repeating
        '{ROW_BEAT, RegPeriod,    32'd0,          1'b0, 1'b1, 32'd0,          1'b1},
        '{ROW_BEAT, RegPeriod,    32'd999,        1'b0, 1'b1, 32'd0,          1'b1},
        '{ROW_BEAT, RegPeriod,    32'd1,          1'b0, 1'b1, 32'd1,          1'b1},
        '{ROW_BEAT, RegPeriod,    32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0,          1'b0},
        // accumulator wraps past 2^32
        '{ROW_BEAT, RegPeriod,    32'hFFFF_FFFF,  1'b0, 1'b1, 32'd0,          1'b1},
        '{ROW_BEAT, RegPeriod,    32'd3000,       1'b1, 1'b1, 32'd3,          1'b1},
        // zero period never fires but still accumulates
        '{ROW_CFG,  RegPeriod,    32'd0,          1'b0, 1'b0, 32'd0,          1'b0},
        '{ROW_BEAT, RegPeriod,    32'd5000,       1'b0, 1'b1, 32'd0,          1'b1},
        // lowered period, zero delta must not fire
        '{ROW_CFG,  RegPeriod,    32'd100,        1'b0, 1'b0, 32'd0,          1'b0},
        '{ROW_BEAT, RegPeriod,    32'd0,          1'b0, 1'b1, 32'd0,          1'b1},
        '{ROW_BEAT, RegPeriod,    32'd1,          1'b0, 1'b0, 32'd0,          1'b0},
        // one-shot: single fire, then disabled until rearm
        '{ROW_CFG,  RegRepeating, 32'd0,          1'b0, 1'b0, 32'd0,          1'b0},
        '{ROW_BEAT, RegPeriod,    32'd250,        1'b0, 1'b1, 32'd1,          1'b0},
        '{ROW_BEAT, RegPeriod,    32'd1000,       1'b0, 1'b1, 32'd0,          1'b0},
        '{ROW_BEAT, RegPeriod,    32'd50,         1'b1, 1'b1, 32'd0,          1'b1},
        '{ROW_BEAT, RegPeriod,    32'd50,         1'b0, 1'b1, 32'd1,          1'b0},
        // stray register indexes
        '{ROW_CFG,  RegSpare2,    32'd1,          1'b0, 1'b0, 32'd0,          1'b0},
        '{ROW_CFG,  RegSpare3,    32'd0,          1'b0, 1'b0, 32'd0,          1'b0},
        '{ROW_BEAT, RegPeriod,    32'd0,          1'b1, 1'b1, 32'd0,          1'b1},
        // repeating flag masked to its lowest bit
        '{ROW_CFG,  RegRepeating, 32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0,          1'b0},
        '{ROW_BEAT, RegPeriod,    32'd250,        1'b0, 1'b1, 32'd2,          1'b1},
        '{ROW_CFG,  RegRepeating, 32'hFFFF_FFFE,  1'b0, 1'b0, 32'd0,          1'b0},
        '{ROW_BEAT, RegPeriod,    32'd60,         1'b0, 1'b1, 32'd1,          1'b0},
        // largest period
        '{ROW_CFG,  RegPeriod,    32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0,          1'b0},
        '{ROW_CFG,  RegRepeating, 32'd1,          1'b0, 1'b0, 32'd0,          1'b0},
        '{ROW_BEAT, RegPeriod,    32'hFFFF_FFFE,  1'b1, 1'b1, 32'd0,          1'b1},
        '{ROW_BEAT, RegPeriod,    32'd1,          1'b0, 1'b1, 32'd1,          1'b1},
        // smallest period, largest quotient
        '{ROW_CFG,  RegPeriod,    32'd1,          1'b0, 1'b0, 32'd0,          1'b0},
        '{ROW_BEAT, RegPeriod,    32'hFFFF_FFFF,  1'b0, 1'b1, 32'hFFFF_FFFF,  1'b1},
        '{ROW_CFG,  RegPeriod,    32'd1000,       1'b0, 1'b0, 32'd0,          1'b0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [DataW-1:0]   cfg_data;

    ait_item_if   item_ch ();
    ait_result_if result_ch ();

    accumulating_interval_timer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    // timer model state and register copies
    logic [DataW-1:0] acc_model;
    logic             enabled_model;
    logic [DataW-1:0] period_reg;
    logic             repeating_reg;

    t_tick pending_ticks [$];

    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned mismatches;
    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned fire_beats;
    int unsigned reg_writes;
    int unsigned cycle_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_ticks.size());
            $display("accumulating_interval_timer: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [DataW-1:0] want,
                                   input logic [DataW-1:0] got);
        if (mismatches < ReportCap)
            $display("ERROR result %0d %s: expected %0d got %0d", results_seen, what, want, got);
        mismatches++;
    endtask

    // predicted outcome of one delta beat, advances the model state
    function automatic t_tick tick_timer(input logic [DataW-1:0] delta, input logic rearm);
        t_tick tick;
        tick.fires = '0;
        if (rearm) begin
            enabled_model = 1'b1;
            acc_model     = '0;
        end
        acc_model = acc_model + delta;
        if (enabled_model && delta != 0 && period_reg != 0 && acc_model >= period_reg) begin
            if (repeating_reg) begin
                tick.fires = acc_model / period_reg;
                acc_model  = acc_model % period_reg;
            end else begin
                enabled_model = 1'b0;
                tick.fires    = 1;
            end
        end
        tick.enabled = enabled_model;
        return tick;
    endfunction

    // deltas in half of the picks scaled to the period so that fires actually happen
    function automatic logic [DataW-1:0] pick_delta();
        logic [DataW-1:0] d;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1, 2:    d = $urandom;
            3, 4, 5: d = (period_reg == 0) ? $urandom_range(1, 1000)
                                           : $urandom_range(1, period_reg / 3 + 1);
            6:       d = period_reg * $urandom_range(1, 5) + $urandom_range(0, 3);
            7:       d = period_reg - $urandom_range(0, 2);
            default: d = $urandom_range(1, 15);
        endcase
        return d;
    endfunction

    function automatic logic [DataW-1:0] pick_period(input int unsigned phase);
        logic [DataW-1:0] p;
        case (phase)
            0:       p = 32'd1;
            1:       p = 32'd0;
            2:       p = 32'hFFFF_FFFF;
            3:       p = $urandom_range(2, 16);
            4:       p = 32'h8000_0000;
            5:       p = $urandom_range(17, 5000);
            6:       p = $urandom;
            default: p = $urandom_range(2, 300);
        endcase
        return p;
    endfunction

    // drop valid, let expected beats arrive, then let the divider settle
    task automatic wait_until_drained();
        item_ch.valid <= 1'b0;
        while (pending_ticks.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
        wait_until_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            RegPeriod:    period_reg = value;
            RegRepeating: repeating_reg = value[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // one delta beat: random idle gap, then hold until accepted
    task automatic send_beat(input logic [DataW-1:0] delta, input logic rearm,
                             input logic typed, input t_tick typed_tick);
        t_tick predicted;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < snd_idle_pct) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.delta <= delta;
        item_ch.rearm <= rearm;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        predicted = tick_timer(delta, rearm);
        pending_ticks.push_back(typed ? typed_tick : predicted);
        beats_sent++;
    endtask

    // result side back-pressure
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            result_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_tick want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_ticks.size() == 0) begin
                report_mismatch("beat with nothing pending, fires", '0, result_ch.fires);
            end else begin
                want = pending_ticks.pop_front();
                if (result_ch.fires !== want.fires)
                    report_mismatch("fires", want.fires, result_ch.fires);
                if (result_ch.enabled_now !== want.enabled)
                    report_mismatch("enabled_now", DataW'(want.enabled),
                                    DataW'(result_ch.enabled_now));
                if (result_ch.fires != 0) fire_beats++;
            end
            results_seen++;
        end
    end

    // stimulus
    initial begin
        t_tick            typed_tick;
        logic [DataW-1:0] rep_word;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = RegPeriod;
        cfg_data      = '0;
        item_ch.valid = 1'b0;
        item_ch.delta = '0;
        item_ch.rearm = 1'b0;
        snd_idle_pct  = 36;
        rcv_idle_pct  = 46;
        mismatches    = 0;
        beats_sent    = 0;
        results_seen  = 0;
        fire_beats    = 0;
        reg_writes    = 0;
        acc_model     = '0;
        enabled_model = 1'b1;
        period_reg    = PeriodReset;
        repeating_reg = RepeatingReset;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < NumRows; r++) begin
            if (DirectedRows[r].kind == ROW_CFG) begin
                write_reg(DirectedRows[r].idx, DirectedRows[r].value);
            end else begin
                typed_tick.fires   = DirectedRows[r].fires;
                typed_tick.enabled = DirectedRows[r].enabled;
                send_beat(DirectedRows[r].value, DirectedRows[r].rearm,
                          DirectedRows[r].typed, typed_tick);
            end
        end

        // random phases, idling schedule moves on every third phase
        for (int unsigned phase = 0; phase < NumPhases; phase++) begin
            case (phase / 3)
                0: begin
                    snd_idle_pct = 36;
                    rcv_idle_pct = 46;
                end
                1: begin
                    snd_idle_pct = 46;
                    rcv_idle_pct = 36;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            write_reg(RegPeriod, pick_period(phase));
            rep_word = ($urandom & ~32'h1) | ((phase % 3) != 1);
            write_reg(RegRepeating, rep_word);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? RegSpare2 : RegSpare3, $urandom);
            typed_tick = '0;
            repeat (BeatsPerPhase)
                send_beat(pick_delta(), ($urandom_range(0, 7) == 0), 1'b0, typed_tick);
        end

        wait_until_drained();

        $display("covered %0d delta beats and %0d register writes over %0d settings",
                 beats_sent, reg_writes, NumPhases + 1);
        $display("checked %0d result beats, %0d of them with fires", results_seen, fire_beats);
        if (mismatches == 0)
            $display("accumulating_interval_timer: match");
        else
            $display("accumulating_interval_timer: mismatch");
        $finish;
    end

endmodule
